// ===== rtl/tcss_pkg.sv =====
`timescale 1ns / 1ps

package tcss_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 4;
	localparam int MAX_SERVICE = 15;
	localparam int BURST_W     = 4;
	localparam int BURST_RESET = 5;
	localparam int BURST_MAX   = 15;
	localparam int QLEN_W      = 8;
	localparam int IDLE_W      = 16;
	localparam int SERVED_W    = 16;
	localparam int WAIT_W      = 32;

	localparam int IN_W  = 1 + TIME_W + 1 + TIME_W;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 3 + 2 * QLEN_W + IDLE_W + SERVED_W + WAIT_W + 2;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TIME_W-1:0] svc_t;

	typedef struct packed {
		logic                reg_dropped;
		logic                ff_dropped;
		logic [WAIT_W-1:0]   wait_total;
		logic [SERVED_W-1:0] served_total;
		logic [IDLE_W-1:0]   idle_total;
		logic [QLEN_W-1:0]   reg_queued;
		logic [QLEN_W-1:0]   ff_queued;
		logic                busy_res;
		logic                served_class;
		logic                started;
	} result_t;

	function automatic svc_t norm_time(input svc_t t);
		svc_t v;
		v = t;
		if (v > TIME_W'(MAX_SERVICE)) begin
			v = TIME_W'(MAX_SERVICE);
		end
		if (v == '0) begin
			v = TIME_W'(1);
		end
		return v;
	endfunction

	function automatic addr_t next_addr(input addr_t a);
		addr_t n;
		if (a == ADDR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = a + ADDR_W'(1);
		end
		return n;
	endfunction

endpackage

// ===== rtl/tcss_ram.sv =====
`timescale 1ns / 1ps

module tcss_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/two_class_service_scheduler.sv =====
`timescale 1ns / 1ps

// Single-server scheduler with a priority queue and a regular queue. Every input beat is one
// tick and produces exactly one result beat; a tick is accepted in every cycle in which the
// output register is empty or being drained, so the sustained rate is one tick per clock.
// The whole tick (start decision, pop, pushes and statistics) is computed in one pass from the
// input beat and the queue state into the output register. Each queue is a RAM with a
// registered read port that always presents the entry at the head for the next tick, with a
// write bypass for a push into an empty queue. Write the burst limit through cfg_we and
// cfg_wdata only while no ticks are in flight (the block does not check); it resets to five.
module two_class_service_scheduler import tcss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [BURST_W-1:0]     cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// ff_arrival, ff_service_time, reg_arrival, reg_service_time, zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// started, served_class, busy_res, ff_queued, reg_queued, idle_total, served_total,
	// wait_total, ff_dropped, reg_dropped, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic               in_ff_arrival;
	svc_t               in_ff_time;
	logic               in_reg_arrival;
	svc_t               in_reg_time;

	logic [BURST_W-1:0]  limit_q;
	logic [BURST_W-1:0]  burst_q;
	svc_t                remaining_q;
	logic [IDLE_W-1:0]   idle_q;
	logic [SERVED_W-1:0] served_q;
	logic [WAIT_W-1:0]   wait_q;
	addr_t               ff_head_q, ff_tail_q, reg_head_q, reg_tail_q;
	cnt_t                ff_count_q, reg_count_q;

	logic  ff_byp_q, reg_byp_q;
	svc_t  ff_byp_data_q, reg_byp_data_q;
	svc_t  ff_rdata, reg_rdata;
	svc_t  ff_head_val, reg_head_val;

	logic                accept;
	logic                free, prefer_ff, pick_ff, pick_reg, started;
	svc_t                svc;
	svc_t                remaining_d;
	logic [BURST_W-1:0]  burst_d;
	logic [IDLE_W-1:0]   idle_d;
	logic [SERVED_W-1:0] served_d;
	logic [WAIT_W+1:0]   wait_sum;
	logic [WAIT_W-1:0]   wait_d;
	cnt_t                ff_cnt_pop, reg_cnt_pop, ff_count_d, reg_count_d;
	logic                ff_push, reg_push, ff_drop, reg_drop;
	addr_t               ff_head_d, reg_head_d, ff_raddr, reg_raddr;
	logic                ff_we, reg_we;

	logic    m_tvalid_q;
	result_t res_q;
	result_t res_d;

	assign in_ff_arrival  = s_tdata[0];
	assign in_ff_time     = s_tdata[TIME_W:1];
	assign in_reg_arrival = s_tdata[TIME_W+1];
	assign in_reg_time    = s_tdata[2*TIME_W+1:TIME_W+2];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(res_q);

	assign ff_head_val  = ff_byp_q ? ff_byp_data_q : ff_rdata;
	assign reg_head_val = reg_byp_q ? reg_byp_data_q : reg_rdata;

	always_comb begin
		free      = (remaining_q == '0);
		prefer_ff = (burst_q < limit_q);
		if (prefer_ff) begin
			pick_ff = free && (ff_count_q != '0);
		end else begin
			pick_ff = free && (ff_count_q != '0) && (reg_count_q == '0);
		end
		pick_reg = free && !pick_ff && (reg_count_q != '0);
		started  = pick_ff || pick_reg;
		svc      = pick_ff ? ff_head_val : reg_head_val;

		if (started) begin
			remaining_d = svc - TIME_W'(1);
		end else if (free) begin
			remaining_d = '0;
		end else begin
			remaining_d = remaining_q - TIME_W'(1);
		end

		burst_d = burst_q;
		if (pick_ff) begin
			if (burst_q < BURST_W'(BURST_MAX)) begin
				burst_d = burst_q + BURST_W'(1);
			end
		end else if (pick_reg) begin
			burst_d = '0;
		end

		idle_d = idle_q;
		if (free && !started && (idle_q != '1)) begin
			idle_d = idle_q + IDLE_W'(1);
		end
		served_d = served_q;
		if (started && (served_q != '1)) begin
			served_d = served_q + SERVED_W'(1);
		end

		ff_cnt_pop  = ff_count_q - CNT_W'(pick_ff);
		reg_cnt_pop = reg_count_q - CNT_W'(pick_reg);
		wait_sum    = (WAIT_W+2)'(wait_q) + (WAIT_W+2)'(ff_cnt_pop) + (WAIT_W+2)'(reg_cnt_pop);
		wait_d      = (wait_sum[WAIT_W+1:WAIT_W] != '0) ? '1 : wait_sum[WAIT_W-1:0];

		ff_push     = in_ff_arrival && (ff_cnt_pop < CNT_W'(QUEUE_DEPTH));
		ff_drop     = in_ff_arrival && !ff_push;
		reg_push    = in_reg_arrival && (reg_cnt_pop < CNT_W'(QUEUE_DEPTH));
		reg_drop    = in_reg_arrival && !reg_push;
		ff_count_d  = ff_cnt_pop + CNT_W'(ff_push);
		reg_count_d = reg_cnt_pop + CNT_W'(reg_push);

		ff_head_d  = pick_ff ? next_addr(ff_head_q) : ff_head_q;
		reg_head_d = pick_reg ? next_addr(reg_head_q) : reg_head_q;
		ff_raddr   = accept ? ff_head_d : ff_head_q;
		reg_raddr  = accept ? reg_head_d : reg_head_q;
		ff_we      = accept && ff_push;
		reg_we     = accept && reg_push;

		res_d.started      = started;
		res_d.served_class = pick_reg;
		res_d.busy_res     = (remaining_d != '0);
		res_d.ff_queued    = QLEN_W'(ff_count_d);
		res_d.reg_queued   = QLEN_W'(reg_count_d);
		res_d.idle_total   = idle_d;
		res_d.served_total = served_d;
		res_d.wait_total   = wait_d;
		res_d.ff_dropped   = ff_drop;
		res_d.reg_dropped  = reg_drop;
	end

	tcss_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_ff_ram (
		.clk   (clk),
		.we    (ff_we),
		.waddr (ff_tail_q),
		.wdata (norm_time(in_ff_time)),
		.raddr (ff_raddr),
		.rdata (ff_rdata)
	);

	tcss_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_reg_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_tail_q),
		.wdata (norm_time(in_reg_time)),
		.raddr (reg_raddr),
		.rdata (reg_rdata)
	);

	always_ff @(posedge clk) begin
		ff_byp_data_q  <= norm_time(in_ff_time);
		reg_byp_data_q <= norm_time(in_reg_time);
		if (accept) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= BURST_W'(BURST_RESET);
			burst_q     <= '0;
			remaining_q <= '0;
			idle_q      <= '0;
			served_q    <= '0;
			wait_q      <= '0;
			ff_head_q   <= '0;
			ff_tail_q   <= '0;
			ff_count_q  <= '0;
			reg_head_q  <= '0;
			reg_tail_q  <= '0;
			reg_count_q <= '0;
			ff_byp_q    <= 1'b0;
			reg_byp_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			ff_byp_q  <= ff_we && (ff_tail_q == ff_raddr);
			reg_byp_q <= reg_we && (reg_tail_q == reg_raddr);
			if (accept) begin
				burst_q     <= burst_d;
				remaining_q <= remaining_d;
				idle_q      <= idle_d;
				served_q    <= served_d;
				wait_q      <= wait_d;
				ff_head_q   <= ff_head_d;
				reg_head_q  <= reg_head_d;
				ff_count_q  <= ff_count_d;
				reg_count_q <= reg_count_d;
				if (ff_push) begin
					ff_tail_q <= next_addr(ff_tail_q);
				end
				if (reg_push) begin
					reg_tail_q <= next_addr(reg_tail_q);
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_ff_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ff_count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("priority queue count beyond depth");

	a_ff_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ff_drop |=> ff_count_q == CNT_W'(QUEUE_DEPTH))
		else $error("priority arrival dropped while queue not full");

	a_reg_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(reg_count_q == '0 || reg_count_q == CNT_W'(QUEUE_DEPTH)) == (reg_tail_q == reg_head_q))
		else $error("regular queue pointers disagree with count");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept && started |=> $past(remaining_q) == '0 && (served_q != $past(served_q)
			|| served_q == '1))
		else $error("service started on a busy server or not counted");
`endif

endmodule
